// File: hw/rtl/tbpc_pkg.sv
// Package for the touch button press classifier.
// Holds state codes, register indexes, item and state structs and helpers.
// No dependencies.
package tbpc_pkg;

    localparam int unsigned CNT_W        = 16;
    localparam int unsigned UPTIME_W     = 14;
    localparam int unsigned STATE_W      = 4;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 16;

    localparam logic [UPTIME_W-1:0] START_WINDOW_TICKS = 14'd10000;
    localparam logic [UPTIME_W-1:0] UPTIME_MAX         = {UPTIME_W{1'b1}};

    // press state codes
    localparam logic [STATE_W-1:0] ST_INIT            = 4'd0;
    localparam logic [STATE_W-1:0] ST_READY_CLEAR     = 4'd1;
    localparam logic [STATE_W-1:0] ST_READY           = 4'd2;
    localparam logic [STATE_W-1:0] ST_UNPRESSED       = 4'd3;
    localparam logic [STATE_W-1:0] ST_RECENT          = 4'd4;
    localparam logic [STATE_W-1:0] ST_REGISTERED      = 4'd5;
    localparam logic [STATE_W-1:0] ST_TRANSITIONAL    = 4'd6;
    localparam logic [STATE_W-1:0] ST_EXTENDED        = 4'd7;
    localparam logic [STATE_W-1:0] ST_EXT_INVALID     = 4'd8;
    localparam logic [STATE_W-1:0] ST_CONSUMED        = 4'd9;
    localparam logic [STATE_W-1:0] ST_CONSUMED_ACTIVE = 4'd10;

    // item modes
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_CONSUME = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRESS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS_EXT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRESS_EXT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSUMED_HOLD = 3'd5;

    typedef struct packed {
        logic mode;
        logic pressed_raw;
        logic consume_target_registered;
    } in_item_t;

    typedef struct packed {
        logic [STATE_W-1:0] press_state;
        logic               press_valid;
        logic               press_extended;
        logic               press_in_progress;
        logic               press_consumed;
        logic               ready_to_work;
        logic               first_window;
    } out_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] init_period_ms;
        logic [CNT_W-1:0] min_press_ms;
        logic [CNT_W-1:0] max_press_ms;
        logic [CNT_W-1:0] min_press_ext_ms;
        logic [CNT_W-1:0] max_press_ext_ms;
        logic [CNT_W-1:0] consumed_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [STATE_W-1:0]  press_state;
        logic                init_started;
        logic [CNT_W-1:0]    init_count;
        logic [CNT_W-1:0]    press_count;
        logic                consumed_started;
        logic [CNT_W-1:0]    consumed_count;
        logic [UPTIME_W-1:0] uptime_count;
        logic                first_window_flag;
    } st_t;

    localparam cfg_t CFG_RESET = '{
        init_period_ms:   16'd1000,
        min_press_ms:     16'd750,
        max_press_ms:     16'd3000,
        min_press_ext_ms: 16'd5000,
        max_press_ext_ms: 16'd10000,
        consumed_hold_ms: 16'd1000
    };

    localparam st_t ST_RESET = '{
        press_state:       ST_INIT,
        init_started:      1'b0,
        init_count:        '0,
        press_count:       '0,
        consumed_started:  1'b0,
        consumed_count:    '0,
        uptime_count:      '0,
        first_window_flag: 1'b1
    };

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// File: hw/rtl/touch_button_press_classifier.sv
// Top level of the touch button press classifier.
// Holds config, classifier state and the result register; uses tbpc_pkg, tbpc_step.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_ready, in_data      | item in
//   out     | out_valid, out_ready, out_data   | result out
//   cfg     | cfg_we, cfg_index, cfg_data      | register write
//
// One item per cycle while the result is not stalled: the state update is one pass of
// compares and increments from the state registers into the result register.
// Reset loads the default thresholds and puts the classifier in init.
// A stalled result holds; in_ready is high whenever the result register is
// empty or being taken in the same cycle.
module touch_button_press_classifier (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  tbpc_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output tbpc_pkg::out_item_t                   out_data,
    input  logic                                  cfg_we,
    input  logic [tbpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tbpc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import tbpc_pkg::*;

    cfg_t      cfg_reg;
    st_t       st_reg;
    st_t       st_next;
    out_item_t res_next;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    logic      in_accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    tbpc_step u_step (
        .cur    (st_reg),
        .cfg    (cfg_reg),
        .item   (in_data),
        .nxt    (st_next),
        .result (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INIT_PERIOD:   cfg_reg.init_period_ms   <= cfg_data;
                CFG_MIN_PRESS:     cfg_reg.min_press_ms     <= cfg_data;
                CFG_MAX_PRESS:     cfg_reg.max_press_ms     <= cfg_data;
                CFG_MIN_PRESS_EXT: cfg_reg.min_press_ext_ms <= cfg_data;
                CFG_MAX_PRESS_EXT: cfg_reg.max_press_ext_ms <= cfg_data;
                CFG_CONSUMED_HOLD: cfg_reg.consumed_hold_ms <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                st_reg <= st_next;
            if (in_accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= res_next;
    end

    // a released tick outside init always lands in unpressed
    a_release_unpressed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_data.mode == MODE_TICK) && !in_data.pressed_raw &&
         (st_reg.press_state != ST_INIT))
        |=> (out_data.press_state == ST_UNPRESSED))
        else $error("released tick did not give unpressed");

    // ready-to-clear is only passed through, never held
    a_no_ready_clear: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.press_state != ST_READY_CLEAR)
        else $error("classifier parked in ready-to-clear");

    // uptime never moves backward
    a_uptime_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (st_reg.uptime_count >= $past(st_reg.uptime_count)))
        else $error("uptime counter went backward");

    // once the start window closes it stays closed
    a_window_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !st_reg.first_window_flag |=> !st_reg.first_window_flag)
        else $error("start window flag set again");

    // result flags agree with the reported state
    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.press_consumed == (out_data.press_state == ST_CONSUMED)) &&
                       (out_data.press_extended == (out_data.press_state == ST_EXTENDED))))
        else $error("result flags disagree with state");

endmodule

// File: hw/rtl/tbpc_step.sv
// Next-state and result logic for one item of the press classifier.
// Purely combinational; depends on tbpc_pkg.
module tbpc_step (
    input  tbpc_pkg::st_t      cur,
    input  tbpc_pkg::cfg_t     cfg,
    input  tbpc_pkg::in_item_t item,
    output tbpc_pkg::st_t      nxt,
    output tbpc_pkg::out_item_t result
);
    import tbpc_pkg::*;

    logic [CNT_W-1:0] press_inc;
    logic [CNT_W-1:0] cons_cnt;

    assign press_inc = sat_inc(cur.press_count);
    assign cons_cnt  = cur.consumed_started ? sat_inc(cur.consumed_count) : '0;

    always_comb
    begin
        nxt = cur;
        if (item.mode == MODE_CONSUME)
        begin
            nxt.press_state = item.consume_target_registered ? ST_CONSUMED_ACTIVE
                                                             : ST_CONSUMED;
        end
        else
        begin
            // start window runs on every tick, uptime checked before increment
            if (cur.first_window_flag && (cur.uptime_count >= START_WINDOW_TICKS))
                nxt.first_window_flag = 1'b0;
            if (cur.uptime_count != UPTIME_MAX)
                nxt.uptime_count = cur.uptime_count + 1'b1;

            if (cur.press_state == ST_INIT)
            begin
                if (!cur.init_started)
                begin
                    nxt.init_started = 1'b1;
                    nxt.init_count   = '0;
                end
                else
                begin
                    nxt.init_count = sat_inc(cur.init_count);
                    // ready-to-clear is passed through in the same tick
                    if (cur.init_count >= cfg.init_period_ms)
                        nxt.press_state = ST_READY;
                end
            end
            else if (!item.pressed_raw)
            begin
                nxt.press_state = ST_UNPRESSED;
                nxt.press_count = '0;
            end
            else if (cur.press_state == ST_UNPRESSED)
            begin
                nxt.press_state      = ST_RECENT;
                nxt.press_count      = '0;
                nxt.consumed_started = 1'b0;
            end
            else
            begin
                nxt.press_count = press_inc;
                case (cur.press_state)
                    ST_RECENT:
                    begin
                        if (press_inc >= cfg.min_press_ms)
                            nxt.press_state = ST_REGISTERED;
                    end
                    ST_REGISTERED:
                    begin
                        if (press_inc >= cfg.max_press_ms)
                            nxt.press_state = ST_TRANSITIONAL;
                    end
                    ST_TRANSITIONAL:
                    begin
                        if (press_inc >= cfg.min_press_ext_ms)
                            nxt.press_state = ST_EXTENDED;
                    end
                    ST_EXTENDED:
                    begin
                        if (press_inc >= cfg.max_press_ext_ms)
                            nxt.press_state = ST_EXT_INVALID;
                    end
                    ST_CONSUMED_ACTIVE:
                    begin
                        nxt.consumed_started = 1'b1;
                        nxt.consumed_count   = cons_cnt;
                        if (cons_cnt >= cfg.consumed_hold_ms)
                            nxt.press_state = ST_CONSUMED;
                    end
                    ST_CONSUMED:
                    begin
                        nxt.consumed_started = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result.press_state       = nxt.press_state;
        result.press_valid       = (nxt.press_state == ST_REGISTERED) ||
                                   (nxt.press_state == ST_CONSUMED_ACTIVE);
        result.press_extended    = (nxt.press_state == ST_EXTENDED);
        result.press_in_progress = (nxt.press_state > ST_UNPRESSED) &&
                                   (nxt.press_state != ST_CONSUMED) &&
                                   (nxt.press_state != ST_EXT_INVALID);
        result.press_consumed    = (nxt.press_state == ST_CONSUMED);
        result.ready_to_work     = (nxt.press_state > ST_READY);
        result.first_window      = nxt.first_window_flag;
    end

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for touch_button_press_classifier.
// Drives ticks and consume commands, predicts each result in-line and checks it.
// Depends on tbpc_pkg and the classifier RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tbpc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always #1 clk = ~clk;

    touch_button_press_classifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // thresholds as last written, indexed by register index
    logic [CNT_W-1:0] thr [6] = '{CFG_RESET.init_period_ms, CFG_RESET.min_press_ms,
                                  CFG_RESET.max_press_ms, CFG_RESET.min_press_ext_ms,
                                  CFG_RESET.max_press_ext_ms, CFG_RESET.consumed_hold_ms};

    // predicted classifier state
    logic [STATE_W-1:0]  p_state = ST_INIT;
    logic                p_init_started = 1'b0;
    logic [CNT_W-1:0]    p_init_cnt = '0;
    logic [CNT_W-1:0]    p_hold_cnt = '0;
    logic                p_consumed_started = 1'b0;
    logic [CNT_W-1:0]    p_consumed_cnt = '0;
    logic [UPTIME_W-1:0] p_uptime = '0;
    logic                p_window = 1'b1;

    out_item_t   pending_results [$];
    int unsigned mismatch_count = 0;
    int unsigned checked_count = 0;
    int unsigned sent_count = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    bit          idle_on = 1'b1;

    function automatic logic [CNT_W-1:0] sat16(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // advance the predicted state by one item and return the expected result
    function automatic out_item_t classify_press(input in_item_t it);
        out_item_t r;
        logic      done;
        if (it.mode == MODE_CONSUME)
        begin
            p_state = it.consume_target_registered ? ST_CONSUMED_ACTIVE : ST_CONSUMED;
        end
        else
        begin
            if (p_window && p_uptime >= START_WINDOW_TICKS)
                p_window = 1'b0;
            if (p_uptime != UPTIME_MAX)
                p_uptime = p_uptime + 1'b1;

            if (p_state == ST_INIT)
            begin
                // first tick only arms the init count
                if (!p_init_started)
                begin
                    p_init_started = 1'b1;
                    p_init_cnt = '0;
                end
                else
                begin
                    done = p_init_cnt >= thr[CFG_INIT_PERIOD];
                    p_init_cnt = sat16(p_init_cnt);
                    if (done)
                        p_state = ST_READY;
                end
            end
            else if (!it.pressed_raw)
            begin
                p_state = ST_UNPRESSED;
                p_hold_cnt = '0;
            end
            else if (p_state == ST_UNPRESSED)
            begin
                p_state = ST_RECENT;
                p_hold_cnt = '0;
                p_consumed_started = 1'b0;
            end
            else
            begin
                p_hold_cnt = sat16(p_hold_cnt);
                case (p_state)
                    ST_RECENT:
                        if (p_hold_cnt >= thr[CFG_MIN_PRESS]) p_state = ST_REGISTERED;
                    ST_REGISTERED:
                        if (p_hold_cnt >= thr[CFG_MAX_PRESS]) p_state = ST_TRANSITIONAL;
                    ST_TRANSITIONAL:
                        if (p_hold_cnt >= thr[CFG_MIN_PRESS_EXT]) p_state = ST_EXTENDED;
                    ST_EXTENDED:
                        if (p_hold_cnt >= thr[CFG_MAX_PRESS_EXT]) p_state = ST_EXT_INVALID;
                    ST_CONSUMED_ACTIVE:
                    begin
                        if (!p_consumed_started)
                        begin
                            p_consumed_started = 1'b1;
                            p_consumed_cnt = '0;
                        end
                        else
                        begin
                            p_consumed_cnt = sat16(p_consumed_cnt);
                        end
                        if (p_consumed_cnt >= thr[CFG_CONSUMED_HOLD])
                            p_state = ST_CONSUMED;
                    end
                    ST_CONSUMED:
                        p_consumed_started = 1'b0;
                    default:
                        ;
                endcase
            end
        end

        r.press_state       = p_state;
        r.press_valid       = (p_state == ST_REGISTERED) || (p_state == ST_CONSUMED_ACTIVE);
        r.press_extended    = p_state == ST_EXTENDED;
        r.press_in_progress = (p_state > ST_UNPRESSED) && (p_state != ST_CONSUMED)
                              && (p_state != ST_EXT_INVALID);
        r.press_consumed    = p_state == ST_CONSUMED;
        r.ready_to_work     = p_state > ST_READY;
        r.first_window      = p_window;
        return r;
    endfunction

    function automatic in_item_t tick_item(input logic pressed);
        in_item_t it;
        it.mode = MODE_TICK;
        it.pressed_raw = pressed;
        it.consume_target_registered = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic in_item_t consume_item(input logic target_registered);
        in_item_t it;
        it.mode = MODE_CONSUME;
        it.pressed_raw = 1'($urandom_range(0, 1));
        it.consume_target_registered = target_registered;
        return it;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(input string name, input logic [STATE_W-1:0] got,
                               input logic [STATE_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      checked_count, name, got, want));
    endtask

    // called and returns at a falling edge; valid stays high after acceptance
    task automatic drive_sample(input in_item_t it);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(classify_press(it));
        sent_count++;
        @(negedge clk);
    endtask

    // stop sending and wait until every result is back, plus the pipeline latency
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic load_thresholds(input logic [CNT_W-1:0] init_p, min_p, max_p,
                                   min_ext, max_ext, hold);
        logic [CNT_W-1:0] vals [6];
        vals = '{init_p, min_p, max_p, min_ext, max_ext, hold};
        settle();
        for (int i = CFG_INIT_PERIOD; i <= CFG_CONSUMED_HOLD; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            thr[i] = vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic test_init_period();
        // longest init period holds the block in init, then a zero period releases it
        load_thresholds(16'hFFFF, CFG_RESET.min_press_ms, CFG_RESET.max_press_ms,
                        CFG_RESET.min_press_ext_ms, CFG_RESET.max_press_ext_ms,
                        CFG_RESET.consumed_hold_ms);
        drive_sample(tick_item(1'b1));
        drive_sample(tick_item(1'b0));
        drive_sample(tick_item(1'b1));
        load_thresholds(16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd1);
        drive_sample(tick_item(1'b0));
    endtask

    task automatic test_ready_state();
        drive_sample(tick_item(1'b1));
        drive_sample(tick_item(1'b1));
        drive_sample(tick_item(1'b0));
    endtask

    task automatic test_hold_ladder();
        // recent, registered, transitional, extended, ext-invalid, then stays
        repeat (7) drive_sample(tick_item(1'b1));
        drive_sample(tick_item(1'b0));
    endtask

    task automatic test_consume();
        drive_sample(consume_item(1'b1));
        repeat (3) drive_sample(tick_item(1'b1));
        drive_sample(consume_item(1'b0));
        drive_sample(tick_item(1'b0));
        drive_sample(consume_item(1'b1));
        drive_sample(tick_item(1'b0));
        drive_sample(consume_item(1'b0));
        drive_sample(tick_item(1'b1));
    endtask

    task automatic random_presses(input int unsigned count);
        int unsigned stop_at;
        int unsigned reach;
        int unsigned linger;
        stop_at = sent_count + count;
        while (sent_count < stop_at)
        begin
            idle_on = $urandom_range(0, 3) != 0;
            reach  = ((thr[CFG_MAX_PRESS_EXT] > 24) ? 24 : thr[CFG_MAX_PRESS_EXT]) + 4;
            linger = ((thr[CFG_CONSUMED_HOLD] > 12) ? 12 : thr[CFG_CONSUMED_HOLD]) + 4;
            if ($urandom_range(0, 49) == 0)
                settle();
            if ($urandom_range(0, 9) < 7)
            begin
                repeat ($urandom_range(1, 3)) drive_sample(tick_item(1'b0));
                repeat ($urandom_range(1, reach)) drive_sample(tick_item(1'b1));
                if ($urandom_range(0, 2) == 0)
                begin
                    drive_sample(consume_item(1'($urandom_range(0, 1))));
                    repeat ($urandom_range(0, linger)) drive_sample(tick_item(1'b1));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    drive_sample(in_item_t'(3'($urandom_range(0, 7))));
            end
        end
    endtask

    task automatic test_random_mix();
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned d;
        load_thresholds(16'($urandom_range(0, 65535)), 16'd2, 16'd5, 16'd8, 16'd12, 16'd3);
        random_presses(360);
        load_thresholds(16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                        16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                        16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)));
        random_presses(360);
        load_thresholds(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_presses(360);
        a = $urandom_range(0, 5);
        b = a + $urandom_range(0, 5);
        c = b + $urandom_range(0, 5);
        d = c + $urandom_range(0, 5);
        load_thresholds(16'd7, 16'(a), 16'(b), 16'(c), 16'(d),
                        16'($urandom_range(0, 8)));
        random_presses(360);
    endtask

    task automatic test_top_thresholds();
        // top thresholds: a held press parks in recent and a held consume stays
        // active; no idling on either side from here on
        idle_on = 1'b0;
        load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drive_sample(tick_item(1'b0));
        repeat (12) drive_sample(tick_item(1'b1));
        drive_sample(consume_item(1'b1));
        repeat (12) drive_sample(tick_item(1'b1));
        drive_sample(tick_item(1'b0));
    endtask

    // result stalls in bursts
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no item outstanding");
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("press_state", out_data.press_state, want.press_state);
                check_field("press_valid", STATE_W'(out_data.press_valid),
                            STATE_W'(want.press_valid));
                check_field("press_extended", STATE_W'(out_data.press_extended),
                            STATE_W'(want.press_extended));
                check_field("press_in_progress", STATE_W'(out_data.press_in_progress),
                            STATE_W'(want.press_in_progress));
                check_field("press_consumed", STATE_W'(out_data.press_consumed),
                            STATE_W'(want.press_consumed));
                check_field("ready_to_work", STATE_W'(out_data.ready_to_work),
                            STATE_W'(want.ready_to_work));
                check_field("first_window", STATE_W'(out_data.first_window),
                            STATE_W'(want.first_window));
            end
            checked_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_init_period();
        test_ready_state();
        test_hold_ladder();
        test_consume();
        test_random_mix();
        test_top_thresholds();
        settle();
        repeat (4) @(negedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
